// File: sv/gdn_pkg.sv
// shared types, constants and calendar tables for the gregorian day number converter
// no dependencies; every other file of the block imports this package

package gdn_pkg;

  // pipeline depth, from the input transfer to the result register
  localparam int NSTAGE = 10;

  // largest year accepted or produced
  localparam logic [17:0] MAX_YEAR = 18'd100000;
  localparam logic [3:0]  MONTH_LAST = 4'd11;

  // floor(n*400/146097) == (n * K_EST) >> 44 for every 26-bit n
  localparam logic [35:0] K_EST = 36'd48165769440;
  localparam int          EST_SHIFT = 44;
  // floor(m/100) == (m * K_DIV100) >> 25 for every 18-bit m
  localparam logic [18:0] K_DIV100 = 19'd335545;
  localparam int          DIV100_SHIFT = 25;

  // command codes
  localparam logic CMD_TO_DAYS = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  // error codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_YEAR  = 3'd1;
  localparam logic [2:0] ERR_MONTH = 3'd2;
  localparam logic [2:0] ERR_DAY   = 3'd3;
  localparam logic [2:0] ERR_ZERO  = 3'd4;

  typedef struct packed {
    logic        command;
    logic [17:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [25:0] day_number;
  } gdn_in_t;

  typedef struct packed {
    logic [25:0] out_day_number;
    logic [17:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  error_code;
  } gdn_out_t;

  // fields that ride along the pipeline beside the arithmetic
  typedef struct packed {
    logic        cmd;
    logic [17:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [25:0] n;
    logic [2:0]  err;
  } gdn_side_t;

  // start of year y = m+1 and leap flags of years m, m+1, m+2
  typedef struct packed {
    logic [26:0] start;
    logic [17:0] m;
    logic        leap0;
    logic        leap1;
    logic        leap2;
  } gdn_ys_t;

  // corrected year, day within the year, its leap flag, and the uncorrected start
  typedef struct packed {
    logic [17:0] y;
    logic [25:0] rem;
    logic        leap;
    logic [25:0] start;
  } gdn_fix_t;

  // days before a zero-based month
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] month);
    logic [8:0] base;
    logic [8:0] adj;
    case (month)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    adj = (leap && month >= 4'd2 && month <= MONTH_LAST) ? 9'd1 : 9'd0;
    return base + adj;
  endfunction

  // days in a zero-based month
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    if (month == 4'd1) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// File: sv/gdn_year_est.sv
// year estimate stages: floor(n*400/146097) by reciprocal multiply in two 18-bit halves
// depends on gdn_pkg

module gdn_year_est import gdn_pkg::*; (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [25:0] n,
  output logic [17:0] q
);

  logic [43:0] p_hi;
  logic [43:0] p_lo;
  logic [44:0] sum;

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_hi <= 44'(n) * 44'(K_EST[35:18]);
      p_lo <= 44'(n) * 44'(K_EST[17:0]);
    end
  end

  assign sum = 45'(p_hi) + 45'(p_lo[43:18]);

  // stage 2: combine and shift
  always_ff @(posedge clk) begin
    if (en[1]) begin
      q <= sum[EST_SHIFT-1:EST_SHIFT-18];
    end
  end

endmodule

// File: sv/gdn_year_start.sv
// year start stages: day number of 1 january of year m+1 and leap flags of m, m+1, m+2
// depends on gdn_pkg

module gdn_year_start import gdn_pkg::*; (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [17:0] m,
  output gdn_ys_t     ys
);

  logic [17:0] m3;
  logic [26:0] m365_3;
  logic [36:0] mq3;
  logic [17:0] m4;
  logic [26:0] m365_4;
  logic [11:0] q100_4;
  logic [6:0]  r100_4;
  logic [11:0] q100_c;
  logic [17:0] r100_c;

  // stage 3: m*365 and m/100 multiply
  always_ff @(posedge clk) begin
    if (en[0]) begin
      m3     <= m;
      m365_3 <= 27'(m) * 27'd365;
      mq3    <= 37'(m) * 37'(K_DIV100);
    end
  end

  assign q100_c = mq3[DIV100_SHIFT+11:DIV100_SHIFT];
  assign r100_c = m3 - 18'(q100_c) * 18'd100;

  // stage 4: quotient and remainder by 100
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m4     <= m3;
      m365_4 <= m365_3;
      q100_4 <= q100_c;
      r100_4 <= r100_c[6:0];
    end
  end

  // stage 5: start sum; m/400 is (m/100)/4
  always_ff @(posedge clk) begin
    if (en[2]) begin
      ys.m     <= m4;
      ys.start <= m365_4 + 27'(m4[17:2]) - 27'(q100_4) + 27'(q100_4[11:2]) + 27'd1;
      ys.leap0 <= (m4[1:0] == 2'd0) && ((r100_4 != 7'd0) || (q100_4[1:0] == 2'd0));
      ys.leap1 <= (m4[1:0] == 2'd3) && ((r100_4 != 7'd99) || (q100_4[1:0] == 2'd3));
      ys.leap2 <= (m4[1:0] == 2'd2) && ((r100_4 != 7'd98) || (q100_4[1:0] == 2'd3));
    end
  end

endmodule

// File: sv/gdn_year_fix.sv
// year correction stages: lower the estimate once, then raise it once, for date lookups
// depends on gdn_pkg

module gdn_year_fix import gdn_pkg::*; (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic        cmd,
  input  logic [25:0] n,
  input  gdn_ys_t     ys,
  output gdn_fix_t    fix
);

  logic        cmd6;
  logic        dec6;
  logic [17:0] y0_6;
  logic [26:0] start6;
  logic [26:0] start_dec6;
  logic [25:0] n6;
  logic        leap0_6;
  logic        leap1_6;
  logic        leap2_6;

  logic        cmd7;
  logic [17:0] y7;
  logic [25:0] rem7;
  logic        leap_y7;
  logic        leap_n7;
  logic [25:0] start7;

  logic [26:0] start_sel;
  logic [8:0]  len7;
  logic        inc;

  // stage 6: decide on lowering, prepare the lowered start
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd6       <= cmd;
      dec6       <= (cmd == CMD_TO_DATE) && (ys.start > {1'b0, n}) && (ys.m != 18'd0);
      y0_6       <= ys.m + 18'd1;
      start6     <= ys.start;
      start_dec6 <= ys.start - (ys.leap0 ? 27'd366 : 27'd365);
      n6         <= n;
      leap0_6    <= ys.leap0;
      leap1_6    <= ys.leap1;
      leap2_6    <= ys.leap2;
    end
  end

  assign start_sel = dec6 ? start_dec6 : start6;

  // stage 7: day within the year
  always_ff @(posedge clk) begin
    if (en[1]) begin
      cmd7    <= cmd6;
      y7      <= dec6 ? y0_6 - 18'd1 : y0_6;
      rem7    <= n6 - start_sel[25:0];
      leap_y7 <= dec6 ? leap0_6 : leap1_6;
      leap_n7 <= dec6 ? leap1_6 : leap2_6;
      start7  <= start6[25:0];
    end
  end

  assign len7 = leap_y7 ? 9'd366 : 9'd365;
  assign inc  = (cmd7 == CMD_TO_DATE) && (rem7 >= 26'(len7));

  // stage 8: raise past the year end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      fix.y     <= inc ? y7 + 18'd1 : y7;
      fix.rem   <= inc ? rem7 - 26'(len7) : rem7;
      fix.leap  <= inc ? leap_n7 : leap_y7;
      fix.start <= start7;
    end
  end

endmodule

// File: sv/gdn_finish.sv
// final stages: month search or month offset, error resolution, result register
// depends on gdn_pkg

module gdn_finish import gdn_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  gdn_side_t  side,
  input  gdn_fix_t   fix,
  output gdn_out_t   result
);

  logic [3:0]  mi_c;
  logic [2:0]  err_c;
  logic        derr;
  logic        yerr;

  logic        cmd9;
  logic [2:0]  err9;
  logic [3:0]  mi9;
  logic        leap9;
  logic [25:0] rem9;
  logic [17:0] y9;
  logic [9:0]  msd9;
  logic [25:0] start9;
  logic [25:0] dday;

  // month search: last month whose start is not past the day of the year
  always_comb begin
    mi_c = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (26'(month_start(fix.leap, 4'(k))) <= fix.rem) begin
        mi_c = 4'(k);
      end
    end
  end

  assign derr = side.day >= month_len(fix.leap, side.month);
  assign yerr = fix.y > MAX_YEAR;

  always_comb begin
    if (side.err != ERR_OK) begin
      err_c = side.err;
    end else if (side.cmd == CMD_TO_DATE) begin
      err_c = yerr ? ERR_YEAR : ERR_OK;
    end else begin
      err_c = derr ? ERR_DAY : ERR_OK;
    end
  end

  // stage 9
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd9   <= side.cmd;
      err9   <= err_c;
      mi9    <= mi_c;
      leap9  <= fix.leap;
      rem9   <= fix.rem;
      y9     <= fix.y;
      msd9   <= 10'(month_start(fix.leap, side.month)) + 10'(side.day);
      start9 <= fix.start;
    end
  end

  assign dday = rem9 - 26'(month_start(leap9, mi9));

  // stage 10: result register
  always_ff @(posedge clk) begin
    if (en[1]) begin
      result.error_code <= err9;
      if (err9 == ERR_OK && cmd9 == CMD_TO_DATE) begin
        result.out_day_number <= 26'd0;
        result.out_year       <= y9;
        result.out_month      <= mi9;
        result.out_day        <= dday[4:0];
      end else if (err9 == ERR_OK) begin
        result.out_day_number <= start9 + 26'(msd9);
        result.out_year       <= 18'd0;
        result.out_month      <= 4'd0;
        result.out_day        <= 5'd0;
      end else begin
        result.out_day_number <= 26'd0;
        result.out_year       <= 18'd0;
        result.out_month      <= 4'd0;
        result.out_day        <= 5'd0;
      end
    end
  end

endmodule

// File: sv/gregorian_day_number_converter_unit.sv
// top level of the gregorian day number converter: handshake, valid bits, side pipeline
// depends on gdn_pkg, gdn_year_est, gdn_year_start, gdn_year_fix, gdn_finish

// Converts between a proleptic Gregorian date (year, zero-based month, zero-based
// day) and a day number where day 1 is 1 january of year 1. Command 0 turns a date
// into a day number, command 1 turns a day number into a date; each item gives
// exactly one result, with error_code set and the other fields zero on a range
// violation. The block is a ten-stage pipeline: a new item may be taken on every
// clock cycle when the output side does not stall. The rate is one item per cycle
// while the result side is not stalled, and it is set by the fully pipelined
// datapath (two multiplier stages for the year estimate, a shared year-start unit
// with a 365 multiply and a reciprocal divide by 100, the year correction stages
// and the month search). Each stage has its own valid bit and moves on when the
// stage after it is empty or moving, so a stall on the result side only holds the
// stages that are full and the input keeps taking items into empty stages.

module gregorian_day_number_converter_unit import gdn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  gdn_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output gdn_out_t result
);

  // valid bit per stage, and stage load enables
  logic [NSTAGE:1]   v;
  logic [NSTAGE+1:1] rdy;
  logic [NSTAGE:1]   en;

  // side pipeline: stage k holds the fields of the item in arithmetic stage k
  gdn_side_t   side_in;
  gdn_side_t   side [1:8];

  logic [17:0] q_est;
  logic [17:0] m_in;
  gdn_ys_t     ys;
  gdn_fix_t    fix;

  // ready ripples back from the result side; an empty stage is always free
  always_comb begin
    rdy[NSTAGE+1] = result_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign en           = rdy[NSTAGE:1];
  assign item_ready   = rdy[1];
  assign result_valid = v[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= item_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // input range checks, in priority order
  always_comb begin
    side_in.cmd   = item.command;
    side_in.year  = item.year;
    side_in.month = item.month;
    side_in.day   = item.day;
    side_in.n     = item.day_number;
    if (item.command == CMD_TO_DATE) begin
      side_in.err = (item.day_number == 26'd0) ? ERR_ZERO : ERR_OK;
    end else if (item.year == 18'd0 || item.year > MAX_YEAR) begin
      side_in.err = ERR_YEAR;
    end else if (item.month > MONTH_LAST) begin
      side_in.err = ERR_MONTH;
    end else begin
      side_in.err = ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1] <= side_in;
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // stages 1-2: year estimate for a day number (estimate minus one comes out)
  gdn_year_est u_est (
    .clk (clk),
    .en  (en[2:1]),
    .n   (item.day_number),
    .q   (q_est)
  );

  // the year-start unit is shared: a date brings year-1, a day number its estimate-1
  assign m_in = (side[2].cmd == CMD_TO_DATE) ? q_est : side[2].year - 18'd1;

  // stages 3-5: start of year and leap flags
  gdn_year_start u_start (
    .clk (clk),
    .en  (en[5:3]),
    .m   (m_in),
    .ys  (ys)
  );

  // stages 6-8: correct the estimate by one year either way
  gdn_year_fix u_fix (
    .clk (clk),
    .en  (en[8:6]),
    .cmd (side[5].cmd),
    .n   (side[5].n),
    .ys  (ys),
    .fix (fix)
  );

  // stages 9-10: month, day, errors and the result register
  gdn_finish u_finish (
    .clk    (clk),
    .en     (en[10:9]),
    .side   (side[8]),
    .fix    (fix),
    .result (result)
  );

endmodule

// File: sim/gregorian_day_number_converter_unit_tb.sv
// self-checking testbench for gregorian_day_number_converter_unit
// depends on gdn_pkg and the converter rtl; needs no files or arguments

module gregorian_day_number_converter_unit_tb import gdn_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    LAST_YEAR = int'(MAX_YEAR);
  // day number of 31 december of the last valid year
  localparam longint LAST_DAY = longint'(LAST_YEAR) * 365 + LAST_YEAR / 4 - LAST_YEAR / 100
                                + LAST_YEAR / 400;
  localparam int    DN_ALL_ONES = (1 << 26) - 1;
  localparam int    IDLE_LIMIT = 4000;   // cycles with no transfer before giving up
  localparam int    LONG_HOLD = 120;     // receiver hold-off for the fill test
  localparam int    RANDOM_ITEMS = 200;  // per random test

  logic     clk;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  gdn_in_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  gdn_out_t result;

  // results predicted at each input transfer, oldest first
  gdn_out_t expected_results[$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int input_stall_cycles = 0;
  int dates_sent = 0;
  int counts_sent = 0;
  int results_by_code[5] = '{default: 0};

  gregorian_day_number_converter_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // calendar arithmetic for the predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // day number of 1 january of year y; year 0 comes out as a common year
  function automatic longint first_day_of_year(longint y);
    longint m;
    m = y - 1;
    return m * 365 + m / 4 - m / 100 + m / 400 + 1;
  endfunction

  function automatic int days_in_month(bit leap, int m);
    case (m)
      1:            return leap ? 29 : 28;
      3, 5, 8, 10:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic int days_before_month(bit leap, int m);
    int base[12];
    base = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    return base[m] + ((leap && m >= 2) ? 1 : 0);
  endfunction

  // expected result of one item; every field not produced stays zero
  function automatic gdn_out_t predict_conversion(gdn_in_t x);
    gdn_out_t r;
    longint   y, n, start, rem, len;
    bit       leap;
    int       mo;
    r = '0;
    if (x.command == CMD_TO_DAYS) begin
      leap = is_leap_year(x.year);
      if (x.year == 0 || x.year > MAX_YEAR) begin
        r.error_code = ERR_YEAR;
      end else if (x.month > MONTH_LAST) begin
        r.error_code = ERR_MONTH;
      end else if (x.day >= days_in_month(leap, x.month)) begin
        r.error_code = ERR_DAY;
      end else begin
        r.out_day_number = 26'(first_day_of_year(x.year) + days_before_month(leap, x.month)
                               + x.day);
      end
    end else begin
      n = x.day_number;
      if (n == 0) begin
        r.error_code = ERR_ZERO;
      end else begin
        // estimate the year, then step it down or up by one
        y = n * 400 / 146097 + 1;
        start = first_day_of_year(y);
        if (start > n && y > 1) begin
          y--;
          start = first_day_of_year(y);
        end
        rem = n - start;
        len = is_leap_year(y) ? 366 : 365;
        if (rem >= len) begin
          rem -= len;
          y++;
        end
        if (y > LAST_YEAR) begin
          r.error_code = ERR_YEAR;
        end else begin
          leap = is_leap_year(y);
          mo = 0;
          for (int k = 1; k < 12; k++) begin
            if (days_before_month(leap, k) <= rem) mo = k;
          end
          r.out_year = 18'(y);
          r.out_month = 4'(mo);
          r.out_day = 5'(rem - days_before_month(leap, mo));
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // fields the command ignores carry random junk
  function automatic gdn_in_t item_for_date(int y, int m, int d);
    gdn_in_t x;
    x.command = CMD_TO_DAYS;
    x.year = 18'(y);
    x.month = 4'(m);
    x.day = 5'(d);
    x.day_number = 26'($urandom);
    return x;
  endfunction

  function automatic gdn_in_t item_for_count(longint n);
    gdn_in_t x;
    x.command = CMD_TO_DATE;
    x.year = 18'($urandom);
    x.month = 4'($urandom);
    x.day = 5'($urandom);
    x.day_number = 26'(n);
    return x;
  endfunction

  // valid year, biased toward century and 400-year edges and both ends
  function automatic int pick_year();
    int step, y;
    case ($urandom_range(3))
      0: y = $urandom_range(1, LAST_YEAR);
      1: begin
        step = $urandom_range(1) ? 400 : 100;
        y = step * $urandom_range(1, LAST_YEAR / step) + $urandom_range(2) - 1;
        if (y > LAST_YEAR) y = LAST_YEAR;
      end
      2: y = $urandom_range(1, 3000);
      default: y = LAST_YEAR - $urandom_range(3);
    endcase
    return y;
  endfunction

  function automatic gdn_in_t random_item();
    gdn_in_t x;
    int      pick, y, mo, len;
    x.command = 1'($urandom);
    x.year = 18'($urandom);
    x.month = 4'($urandom);
    x.day = 5'($urandom);
    x.day_number = 26'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      // well-formed date, often the last day of a month
      x.command = CMD_TO_DAYS;
      y = pick_year();
      mo = $urandom_range(11);
      len = days_in_month(is_leap_year(y), mo);
      x.year = 18'(y);
      x.month = 4'(mo);
      x.day = 5'(($urandom_range(3) == 0) ? len - 1 : $urandom_range(len - 1));
    end else if (pick < 75) begin
      // day number in range, half of them next to a new year
      x.command = CMD_TO_DATE;
      if ($urandom_range(1)) begin
        x.day_number = 26'($urandom_range(1, 32'(LAST_DAY)));
      end else begin
        x.day_number = 26'(first_day_of_year(pick_year()) + $urandom_range(2) - 1);
      end
    end else if (pick < 90) begin
      // one range violation at a time
      y = pick_year();
      mo = $urandom_range(11);
      x.command = CMD_TO_DAYS;
      x.year = 18'(y);
      x.month = 4'(mo);
      x.day = 5'($urandom_range(days_in_month(is_leap_year(y), mo) - 1));
      case ($urandom_range(3))
        0: x.year = $urandom_range(1) ? 18'd0
                                      : 18'($urandom_range(LAST_YEAR + 1, 18'h3FFFF));
        1: x.month = 4'($urandom_range(12, 15));
        2: x.day = 5'($urandom_range(days_in_month(is_leap_year(y), mo), 31));
        default: begin
          x.command = CMD_TO_DATE;
          x.day_number = $urandom_range(1) ? 26'd0
                         : 26'($urandom_range(32'(LAST_DAY + 1), DN_ALL_ONES));
        end
      endcase
    end
    // otherwise all fields stay fully random
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one transfer per call, valid held across back-to-back items
  // ---------------------------------------------------------------------------

  task automatic send_item(gdn_in_t x);
    // each cycle idles with the requested chance
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    // transfer happened at this edge
    expected_results.push_back(predict_conversion(x));
    if (x.command == CMD_TO_DAYS) dates_sent++;
    else counts_sent++;
  endtask

  // sender stops offering until every predicted result has been checked
  task automatic wait_all_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, long hold-off on request, and the checker
  // ---------------------------------------------------------------------------

  task automatic check_result(gdn_out_t got);
    gdn_out_t exp_r;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: %p", got);
      error_count++;
      return;
    end
    exp_r = expected_results.pop_front();
    if (exp_r.error_code <= ERR_ZERO) results_by_code[exp_r.error_code]++;
    if (got.out_day_number !== exp_r.out_day_number) begin
      $error("out_day_number: expected %0d, got %0d", exp_r.out_day_number, got.out_day_number);
      error_count++;
    end
    if (got.out_year !== exp_r.out_year) begin
      $error("out_year: expected %0d, got %0d", exp_r.out_year, got.out_year);
      error_count++;
    end
    if (got.out_month !== exp_r.out_month) begin
      $error("out_month: expected %0d, got %0d", exp_r.out_month, got.out_month);
      error_count++;
    end
    if (got.out_day !== exp_r.out_day) begin
      $error("out_day: expected %0d, got %0d", exp_r.out_day, got.out_day);
      error_count++;
    end
    if (got.error_code !== exp_r.error_code) begin
      $error("error_code: expected %0d, got %0d", exp_r.error_code, got.error_code);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result(result);
    // a requested hold-off is counted here, independent of the sender
    if (holds_asked != holds_done) begin
      holds_done = holds_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!rst && item_valid && !item_ready) input_stall_cycles <= input_stall_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every error code, leap rules and the year correction edges
  task automatic test_directed();
    gdn_in_t x;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(item_for_date(1, 0, 0));
    send_item(item_for_date(LAST_YEAR, 11, 30));
    send_item(item_for_date(0, 0, 0));
    send_item(item_for_date(LAST_YEAR + 1, 0, 0));
    x = '1;
    x.command = CMD_TO_DAYS;               // year error wins over month and day
    send_item(x);
    send_item(item_for_date(2000, 12, 0));
    send_item(item_for_date(2000, 15, 31));
    send_item(item_for_date(2000, 1, 28)); // 400-year leap
    send_item(item_for_date(1900, 1, 28)); // century, not leap
    send_item(item_for_date(2024, 1, 28));
    send_item(item_for_date(2023, 1, 28));
    send_item(item_for_date(2023, 3, 30));
    send_item(item_for_date(2023, 0, 31));
    send_item(item_for_count(0));
    send_item(item_for_count(1));
    send_item(item_for_count(LAST_DAY));
    send_item(item_for_count(LAST_DAY + 1));
    send_item('1);                         // largest day number, unused fields all ones
    x = '1;
    x.day_number = 26'd1;
    send_item(x);
    send_item(item_for_count(first_day_of_year(2001) - 1));
    send_item(item_for_count(first_day_of_year(2000) + 59));
    send_item(item_for_count(first_day_of_year(1901) - 1));
    send_item(item_for_count(146097));     // estimate one year too high
    send_item(item_for_count(146098));
    send_item(item_for_count(first_day_of_year(101) - 1));
    wait_all_results();
  endtask

  task automatic run_random(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (RANDOM_ITEMS) send_item(random_item());
    wait_all_results();
  endtask

  task automatic test_streaming();
    run_random(0, 0);
  endtask

  task automatic test_sender_idle();
    run_random(66, 0);
  endtask

  task automatic test_receiver_stall();
    run_random(0, 66);
  endtask

  task automatic test_both_idle();
    run_random(13, 13);
  endtask

  // receiver holds off long enough that the pipeline fills and the input stalls
  task automatic test_pipeline_fill();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holds_asked++;
    repeat (40) send_item(random_item());
    wait_all_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_streaming();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_pipeline_fill();
    // let any stray result show up before the verdict
    repeat (NSTAGE + 5) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    $display("covered %0d date-to-number and %0d number-to-date transfers, %0d input stall cycles",
             dates_sent, counts_sent, input_stall_cycles);
    $display("result codes ok/year/month/day/zero: %0d/%0d/%0d/%0d/%0d", results_by_code[0],
             results_by_code[1], results_by_code[2], results_by_code[3], results_by_code[4]);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
sv/gdn_pkg.sv
sv/gdn_year_est.sv
sv/gdn_year_start.sv
sv/gdn_year_fix.sv
sv/gdn_finish.sv
sv/gregorian_day_number_converter_unit.sv
sim/gregorian_day_number_converter_unit_tb.sv
